[rtl/lmfr_pkg.sv]
// shared types and constants of the led matrix frame refresh block
// no dependencies
`default_nettype none

package lmfr_pkg;

    localparam int MAX_MATRICES = 4;
    localparam int ROWS         = 8;
    localparam int DEPTH        = ROWS * MAX_MATRICES;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int N_W          = $clog2(MAX_MATRICES + 1);
    localparam int X_W          = 6;
    localparam int CMP_W        = X_W + N_W + 3;
    localparam int PROD_W       = N_W + 4;
    localparam int FIFO_DEPTH   = 2;
    localparam int FP_W         = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 16;

    typedef enum logic [1:0] {
        OP_PIXEL   = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_REFRESH = 2'd2,
        OP_BCAST   = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic [2:0]       bit_sel;
        logic             on;
        logic [3:0]       sel;
        logic [7:0]       val;
        logic [N_W-1:0]   n;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/lmfr_front.sv]
// front end: chip count register, input decode, pixel address calculation
// depends on lmfr_pkg
`default_nettype none

module lmfr_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [3:0]                    i_cfg_wdata,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [lmfr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic [1:0]                    s_axis_tuser,
    input  wire logic                          i_full,
    output logic                               o_push,
    output lmfr_pkg::t_cmd                     o_cmd
);

    logic [3:0]                    r_num_matrices;
    logic [lmfr_pkg::N_W-1:0]      w_n;
    logic [5:0]                    w_x;
    logic [2:0]                    w_y;
    logic [lmfr_pkg::PROD_W-1:0]   w_prod;
    logic                          w_in_range;
    lmfr_pkg::t_op                 w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_matrices <= 4'd4;
        end else if (i_cfg_we) begin
            r_num_matrices <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_num_matrices == 4'd0) begin
            w_n = lmfr_pkg::N_W'(1);
        end else if (32'(r_num_matrices) > lmfr_pkg::MAX_MATRICES) begin
            w_n = lmfr_pkg::N_W'(lmfr_pkg::MAX_MATRICES);
        end else begin
            w_n = lmfr_pkg::N_W'(r_num_matrices);
        end
    end

    assign w_op = lmfr_pkg::t_op'(s_axis_tuser);
    assign w_x  = s_axis_tdata[5:0];
    assign w_y  = s_axis_tdata[8:6];

    assign w_in_range = lmfr_pkg::CMP_W'(w_x) < lmfr_pkg::CMP_W'({w_n, 3'b000});
    assign w_prod = lmfr_pkg::PROD_W'(w_y) * lmfr_pkg::PROD_W'(w_n)
                  + lmfr_pkg::PROD_W'(w_x[5:3]);

    assign s_axis_tready = !i_full;
    assign o_push = s_axis_tvalid && !i_full
                    && ((w_op != lmfr_pkg::OP_PIXEL) || w_in_range);

    always_comb begin
        o_cmd.op      = w_op;
        o_cmd.idx     = w_prod[lmfr_pkg::IDX_W-1:0];
        o_cmd.bit_sel = w_x[2:0];
        o_cmd.on      = s_axis_tdata[9];
        o_cmd.sel     = s_axis_tdata[13:10];
        o_cmd.val     = s_axis_tdata[21:14];
        o_cmd.n       = w_n;
    end

endmodule

`default_nettype wire

[rtl/lmfr_fifo.sv]
// short command queue between front end and back end
// depends on lmfr_pkg
`default_nettype none

module lmfr_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  lmfr_pkg::t_cmd     i_data,
    input  wire logic          i_pop,
    output lmfr_pkg::t_cmd     o_data,
    output logic               o_full,
    output logic               o_empty
);

    lmfr_pkg::t_cmd              r_mem [lmfr_pkg::FIFO_DEPTH];
    logic [lmfr_pkg::FP_W-1:0]   r_wr;
    logic [lmfr_pkg::FP_W-1:0]   r_rd;
    logic [lmfr_pkg::FP_W:0]     r_count;
    logic                        w_do_push;
    logic                        w_do_pop;

    assign o_full    = (r_count == (lmfr_pkg::FP_W + 1)'(lmfr_pkg::FIFO_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (32'(r_wr) == lmfr_pkg::FIFO_DEPTH - 1) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (32'(r_rd) == lmfr_pkg::FIFO_DEPTH - 1) ? '0 : r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/lmfr_back.sv]
// back end: frame buffer, pixel and clear execution, serial word sequencer
// depends on lmfr_pkg
`default_nettype none

module lmfr_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  lmfr_pkg::t_cmd                       i_cmd,
    input  wire logic                            i_cmd_valid,
    output logic                                 o_pop,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [lmfr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    logic [7:0]                  r_buf [lmfr_pkg::DEPTH];
    t_state                      r_state;
    logic                        r_bcast;
    logic [3:0]                  r_sel;
    logic [7:0]                  r_val;
    logic [lmfr_pkg::N_W-1:0]    r_n;
    logic [lmfr_pkg::N_W-1:0]    r_chip;
    logic [2:0]                  r_row;
    logic [lmfr_pkg::IDX_W-1:0]  r_idx;
    logic                        r_out_valid;
    logic [3:0]                  r_out_addr;
    logic [7:0]                  r_out_data;
    logic                        r_out_fend;
    logic                        r_out_last;
    logic                        w_load;
    logic                        w_fend;
    logic                        w_last;
    logic [7:0]                  w_mask;

    assign o_pop  = (r_state == ST_IDLE) && i_cmd_valid;
    assign w_load = (r_state == ST_RUN) && (!r_out_valid || m_axis_tready);
    assign w_fend = (r_chip == r_n - lmfr_pkg::N_W'(1));
    assign w_last = w_fend && (r_bcast || (32'(r_row) == lmfr_pkg::ROWS - 1));
    assign w_mask = 8'h80 >> i_cmd.bit_sel;

    // frame buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lmfr_pkg::DEPTH; i++) begin
                r_buf[i] <= 8'h00;
            end
        end else if (o_pop) begin
            case (i_cmd.op)
                lmfr_pkg::OP_PIXEL: begin
                    r_buf[i_cmd.idx] <= i_cmd.on ? (r_buf[i_cmd.idx] | w_mask)
                                                 : (r_buf[i_cmd.idx] & ~w_mask);
                end
                lmfr_pkg::OP_CLEAR: begin
                    for (int i = 0; i < lmfr_pkg::DEPTH; i++) begin
                        r_buf[i] <= 8'h00;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop && (i_cmd.op inside {lmfr_pkg::OP_REFRESH,
                                                   lmfr_pkg::OP_BCAST})) begin
                        r_state <= ST_RUN;
                        r_bcast <= (i_cmd.op == lmfr_pkg::OP_BCAST);
                        r_sel   <= i_cmd.sel;
                        r_val   <= i_cmd.val;
                        r_n     <= i_cmd.n;
                        r_chip  <= '0;
                        r_row   <= '0;
                        r_idx   <= '0;
                    end
                end
                ST_RUN: begin
                    if (w_load) begin
                        r_out_addr <= r_bcast ? r_sel : ({1'b0, r_row} + 4'd1);
                        r_out_data <= r_bcast ? r_val : r_buf[r_idx];
                        r_out_fend <= w_fend;
                        r_out_last <= w_last;
                        r_idx      <= r_idx + 1'b1;
                        if (w_fend) begin
                            r_chip <= '0;
                            r_row  <= r_row + 3'd1;
                        end else begin
                            r_chip <= r_chip + 1'b1;
                        end
                        if (w_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_data, r_out_addr};
    assign m_axis_tuser  = r_out_fend;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

[rtl/led_matrix_frame_refresh.sv]
// top level of the led matrix frame refresh block: front end, queue, back end
// depends on lmfr_pkg, lmfr_front, lmfr_fifo, lmfr_back
// pixel write and clear: executed in the back end while idle, one per cycle sustained while no refresh runs
// refresh: 8*N words, one word per cycle while the output is not stalled; broadcast: N words
// first word passes the queue, the back end state and the output register after the transfer in
// sync reset: frame buffer zero, chip count 4, queue and output empty
`default_nettype none

module led_matrix_frame_refresh (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [3:0]                      i_cfg_wdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // pos_x[5:0], pos_y[8:6], pixel_on[9], reg_select[13:10], reg_value[21:14]
    input  wire logic [lmfr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  wire logic [1:0]                      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // reg_addr[3:0], reg_data[11:4]
    output logic [lmfr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // frame_end[0]
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast
);

    logic           w_push;
    logic           w_full;
    logic           w_empty;
    logic           w_pop;
    lmfr_pkg::t_cmd w_cmd_in;
    lmfr_pkg::t_cmd w_cmd_out;

    lmfr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_cmd         (w_cmd_in)
    );

    lmfr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .i_pop   (w_pop),
        .o_data  (w_cmd_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    lmfr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd_out),
        .i_cmd_valid   (!w_empty),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

[rtl/lmfr_checker.sv]
// port-level assertions for led_matrix_frame_refresh, bound to the top level
// depends on lmfr_pkg
`default_nettype none

module lmfr_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [lmfr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                            m_axis_tuser,
    input wire logic                            m_axis_tlast
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output transfer changed");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("last word without frame end");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:12] == 4'b0000))
        else $error("output pad bits not zero");

endmodule

bind led_matrix_frame_refresh lmfr_checker u_lmfr_checker (.*);

`default_nettype wire
